>>> rtl/core/swks_pkg.sv
// ----------------------------------------------------------------------------
// swks_pkg: shared definitions for the sliding window key selector
// Field widths, operation codes, default depths and the command/status
// bundles exchanged between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package swks_pkg;

  // Beat field widths
  localparam int OP_W   = 2;
  localparam int IDX_W  = 8;
  localparam int RAW_W  = 8;
  localparam int POS_W  = 31;
  localparam int EXP_W  = 31;
  localparam int WIN_W  = 31;
  localparam int KEY_W  = 6;
  localparam int ROW_W  = 7;

  // Default store depths
  localparam int TOKEN_DEPTH_DEF = 64;
  localparam int RAW_DEPTH_DEF   = 256;

  // Operation codes
  localparam logic [OP_W-1:0] OP_EXPIRY = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Controller -> datapath
  typedef struct packed {
    logic exp_wr;    // write expiry table from the input beat
    logic tok_wr;    // write token tables from the input beat
    logic q_start;   // latch query index, apply restart
    logic rd_query;  // token tables read at the query index
    logic q_latch;   // capture threshold and query raw position
    logic lp_inc;    // advance left pointer
    logic key_load;  // key <= left pointer
    logic scan_clr;  // count <= 1
    logic hit_wr;    // record visibility of current key
    logic key_inc;   // key <= key + 1
    logic out_load;  // load output register
    logic out_last;  // loaded beat is the query itself
  } swks_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic idx_tok_ok;  // input index within token tables
    logic idx_raw_ok;  // input index within expiry table
    logic lp_ge_q;     // left pointer at or past query
    logic key_ge_q;    // scan key reached query
    logic pos_below;   // stored true position below threshold
    logic hit_key;     // current key was found visible
    logic slot_free;   // output register can take a beat
  } swks_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/swks_if.sv
// ----------------------------------------------------------------------------
// swks_if: channel interfaces of the sliding window key selector
// Input item channel, result channel and window register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface swks_in_if import swks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] index;
  logic [RAW_W-1:0] raw_position;
  logic [POS_W-1:0] true_position;
  logic [EXP_W-1:0] expiry_value;
  logic             restart;

  modport source (output valid, operation, index, raw_position, true_position,
                  expiry_value, restart, input ready);
  modport sink (input valid, operation, index, raw_position, true_position,
                expiry_value, restart, output ready);
endinterface

interface swks_out_if import swks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_index;
  logic [ROW_W-1:0] row_length;
  logic             last;

  modport source (output valid, key_index, row_length, last, input ready);
  modport sink (input valid, key_index, row_length, last, output ready);
endinterface

interface swks_cfg_if import swks_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window;

  modport source (output valid, window, input ready);
  modport sink (input valid, window, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sliding_window_key_selector.sv
// ----------------------------------------------------------------------------
// sliding_window_key_selector: top level
// Expiry table writes, token loads and queries; a query emits its visible
// earlier keys in ascending order, then itself, each beat with row length.
// ----------------------------------------------------------------------------
// Writes and loads: done on acceptance; the next beat is taken in the following cycle.
// Query: accept, table read, pointer steps (request, compare), a scan of each
// key from the pointer up (raw read, expiry read, compare), an emit pass over
// those keys (flag read, emit) and the query beat; output stalls hold the emit
// pass, and the next beat is taken only after the query beat is loaded.
// Reset (rst, sync, active high) clears pointer, window and output valid;
// the tables hold nothing defined until written, and no clearing pass runs.
`default_nettype none

module sliding_window_key_selector import swks_pkg::*; #(
  parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF,
  parameter int RAW_DEPTH   = RAW_DEPTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  swks_in_if.sink   in,
  swks_out_if.source out,
  swks_cfg_if.sink  cfg
);

  swks_cmd_t cmd;
  swks_sts_t sts;

  // Window register is a plain flop; a write beat is always taken.
  assign cfg.ready = 1'b1;

  // Sequencer: one item in flight, three passes per query
  swks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in.valid),
    .in_op    (in.operation),
    .in_ready (in.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Tables, pointer, scan state and the output beat register
  swks_dp #(
    .TOKEN_DEPTH (TOKEN_DEPTH),
    .RAW_DEPTH   (RAW_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_index         (in.index),
    .in_raw_position  (in.raw_position),
    .in_true_position (in.true_position),
    .in_expiry_value  (in.expiry_value),
    .in_restart       (in.restart),
    .cfg_valid        (cfg.valid),
    .cfg_window       (cfg.window),
    .out_valid        (out.valid),
    .out_ready        (out.ready),
    .out_key_index    (out.key_index),
    .out_row_length   (out.row_length),
    .out_last         (out.last)
  );

  // A key beat ahead of the query beat means at least two in the row.
  a_row_len: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.last |-> out.row_length > ROW_W'(1))
    else $error("non-final beat with row length below two");

  // The left pointer never moves past the query token.
  a_lp_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.lp_inc |-> !sts.lp_ge_q)
    else $error("left pointer advanced at or past query");

  // A result beat is loaded only into a free output register.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.slot_free)
    else $error("output register overwritten while holding a beat");

endmodule

`default_nettype wire

>>> rtl/core/swks_ctrl.sv
// ----------------------------------------------------------------------------
// swks_ctrl: sequencer of the sliding window key selector
// Accepts one beat at a time, runs pointer advance, count scan and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module swks_ctrl import swks_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic [OP_W-1:0] in_op,
  output logic                 in_ready,
  input  wire swks_sts_t       sts,
  output swks_cmd_t            cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_QREQ     = 4'd1;
  localparam logic [3:0] S_QLAT     = 4'd2;
  localparam logic [3:0] S_ADV_REQ  = 4'd3;
  localparam logic [3:0] S_ADV_CMP  = 4'd4;
  localparam logic [3:0] S_SCAN_RAW = 4'd5;
  localparam logic [3:0] S_SCAN_EXP = 4'd6;
  localparam logic [3:0] S_SCAN_CMP = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;
  localparam logic [3:0] S_EMIT_RD  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            OP_EXPIRY: cmd.exp_wr = sts.idx_raw_ok;
            OP_LOAD:   cmd.tok_wr = sts.idx_tok_ok;
            OP_QUERY: begin
              if (sts.idx_tok_ok) begin
                cmd.q_start = 1'b1;
                state_next  = S_QREQ;
              end
            end
            default: ;
          endcase
        end
      end
      S_QREQ: begin
        cmd.rd_query = 1'b1;
        state_next   = S_QLAT;
      end
      S_QLAT: begin
        cmd.q_latch = 1'b1;
        state_next  = S_ADV_REQ;
      end
      S_ADV_REQ: begin
        if (sts.lp_ge_q) begin
          cmd.key_load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN_RAW;
        end else begin
          state_next = S_ADV_CMP;
        end
      end
      S_ADV_CMP: begin
        if (sts.pos_below) begin
          cmd.lp_inc = 1'b1;
          state_next = S_ADV_REQ;
        end else begin
          cmd.key_load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next   = S_SCAN_RAW;
        end
      end
      S_SCAN_RAW: begin
        if (sts.key_ge_q) begin
          cmd.key_load = 1'b1;
          state_next   = S_EMIT_RD;
        end else begin
          state_next = S_SCAN_EXP;
        end
      end
      S_SCAN_EXP: begin
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.hit_wr  = 1'b1;
        cmd.key_inc = 1'b1;
        state_next  = S_SCAN_RAW;
      end
      S_EMIT_RD: begin
        // hit flag of the current key is registered this cycle
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (sts.key_ge_q) begin
          if (sts.slot_free) begin
            cmd.out_load = 1'b1;
            cmd.out_last = 1'b1;
            state_next   = S_IDLE;
          end
        end else if (!sts.hit_key) begin
          cmd.key_inc = 1'b1;
          state_next  = S_EMIT_RD;
        end else if (sts.slot_free) begin
          cmd.out_load = 1'b1;
          cmd.key_inc  = 1'b1;
          state_next   = S_EMIT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/swks_dp.sv
// ----------------------------------------------------------------------------
// swks_dp: datapath of the sliding window key selector
// Token and expiry tables, left pointer, scan key, hit flags, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module swks_dp import swks_pkg::*; #(
  parameter int TOKEN_DEPTH = TOKEN_DEPTH_DEF,
  parameter int RAW_DEPTH   = RAW_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire swks_cmd_t        cmd,
  output swks_sts_t             sts,
  // input beat payload
  input  wire logic [IDX_W-1:0] in_index,
  input  wire logic [RAW_W-1:0] in_raw_position,
  input  wire logic [POS_W-1:0] in_true_position,
  input  wire logic [EXP_W-1:0] in_expiry_value,
  input  wire logic             in_restart,
  // window register write
  input  wire logic             cfg_valid,
  input  wire logic [WIN_W-1:0] cfg_window,
  // result beat
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [KEY_W-1:0]      out_key_index,
  output logic [ROW_W-1:0]      out_row_length,
  output logic                  out_last
);

  localparam int TW  = $clog2(TOKEN_DEPTH);
  localparam int RW  = $clog2(RAW_DEPTH);
  localparam int CW  = $clog2(TOKEN_DEPTH + 1);
  localparam int THW = POS_W + 2;

  logic [RAW_W-1:0] raw_mem [TOKEN_DEPTH];
  logic [POS_W-1:0] pos_mem [TOKEN_DEPTH];
  logic [EXP_W-1:0] exp_mem [RAW_DEPTH];
  logic             hit     [TOKEN_DEPTH];

  logic [WIN_W-1:0]       window;
  logic [TW-1:0]          qidx;
  logic [TW-1:0]          lp;
  logic [TW-1:0]          key;
  logic [CW-1:0]          count;
  logic                   hit_q;
  logic signed [THW-1:0]  thr;
  logic [RAW_W-1:0]       qraw;

  logic [TW-1:0]    raw_addr;
  logic [TW-1:0]    pos_addr;
  logic [RW-1:0]    exp_addr;
  logic [RAW_W-1:0] raw_q;
  logic [POS_W-1:0] pos_q;
  logic [EXP_W-1:0] exp_q;
  logic             raw_oor;
  logic             oor_q;
  logic             hit_now;

  // Memories: write from the input beat, registered read
  assign raw_addr = cmd.rd_query ? qidx : key;
  assign pos_addr = cmd.rd_query ? qidx : lp;
  assign raw_oor  = 32'(raw_q) >= RAW_DEPTH;
  assign exp_addr = raw_oor ? '0 : RW'(raw_q);

  always_ff @(posedge clk) begin
    if (cmd.tok_wr) begin
      raw_mem[TW'(in_index)] <= in_raw_position;
      pos_mem[TW'(in_index)] <= in_true_position;
    end
    raw_q <= raw_mem[raw_addr];
    pos_q <= pos_mem[pos_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_wr) begin
      exp_mem[RW'(in_index)] <= in_expiry_value;
    end
    exp_q <= exp_mem[exp_addr];
    oor_q <= raw_oor;
  end

  // Window register
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (cfg_valid) begin
      window <= cfg_window;
    end
  end

  // Query context and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      lp <= '0;
    end else if (cmd.q_start && in_restart) begin
      lp <= '0;
    end else if (cmd.lp_inc) begin
      lp <= lp + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      qidx <= TW'(in_index);
    end
    if (cmd.q_latch) begin
      thr  <= $signed({2'b00, pos_q}) - $signed({2'b00, window});
      qraw <= raw_q;
    end
    if (cmd.key_load) begin
      key <= lp;
    end else if (cmd.key_inc) begin
      key <= key + 1'b1;
    end
  end

  // Visibility: expiry beyond the query's raw position, never for an
  // out-of-table raw position
  assign hit_now = !oor_q && (exp_q > EXP_W'(qraw));

  // Hit flags: every key from the pointer up is written by the scan before
  // the emit pass reads it, so no clearing is needed
  always_ff @(posedge clk) begin
    if (cmd.hit_wr) begin
      hit[key] <= hit_now;
    end
    hit_q <= hit[key];
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_clr) begin
      count <= CW'(1);
    end else if (cmd.hit_wr && hit_now) begin
      count <= count + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_key_index  <= KEY_W'(cmd.out_last ? qidx : key);
      out_row_length <= ROW_W'(count);
      out_last       <= cmd.out_last;
    end
  end

  always_comb begin
    sts.idx_tok_ok = 32'(in_index) < TOKEN_DEPTH;
    sts.idx_raw_ok = 32'(in_index) < RAW_DEPTH;
    sts.lp_ge_q    = lp >= qidx;
    sts.key_ge_q   = key >= qidx;
    sts.pos_below  = $signed({2'b00, pos_q}) < thr;
    sts.hit_key    = hit_q;
    sts.slot_free  = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

>>> dv/sliding_window_key_selector_checker.sv
// ----------------------------------------------------------------------------
// sliding_window_key_selector_checker: result predictor and scoreboard
// Watches the item, result and window channels, keeps its own copy of the
// tables and the left pointer, and compares each result beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_key_selector_checker import swks_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  swks_in_if   in_ch,
  swks_out_if  out_ch,
  swks_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ROW_W-1:0] row_len;
    logic             last;
  } key_beat_t;

  key_beat_t        expected_keys [$];

  logic [RAW_W-1:0] raw_of_tok [TOKEN_DEPTH_DEF];
  logic [POS_W-1:0] pos_of_tok [TOKEN_DEPTH_DEF];
  logic [EXP_W-1:0] expiry_tab [RAW_DEPTH_DEF];
  logic [WIN_W-1:0] span;
  int               left_ptr;
  int               errors;

  // Update the tables for one accepted item; a query queues its key beats.
  task automatic select_keys(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [RAW_W-1:0] raw, input logic [POS_W-1:0] pos,
                             input logic [EXP_W-1:0] expv, input logic restart);
    longint    floor_pos;
    int        q;
    int        hits [$];
    key_beat_t beat;
    q = int'(idx);
    if (op == OP_EXPIRY) begin
      if (q < RAW_DEPTH_DEF) expiry_tab[q] = expv;
    end else if (op == OP_LOAD) begin
      if (q < TOKEN_DEPTH_DEF) begin
        raw_of_tok[q] = raw;
        pos_of_tok[q] = pos;
      end
    end else if (op == OP_QUERY && q < TOKEN_DEPTH_DEF) begin
      if (restart) left_ptr = 0;
      // signed threshold, may go negative
      floor_pos = longint'(pos_of_tok[q]) - longint'(span);
      while (left_ptr < q && longint'(pos_of_tok[left_ptr]) < floor_pos)
        left_ptr++;
      for (int k = left_ptr; k < q; k++)
        if (expiry_tab[raw_of_tok[k]] > EXP_W'(raw_of_tok[q])) hits.push_back(k);
      foreach (hits[i]) begin
        beat.key     = KEY_W'(hits[i]);
        beat.row_len = ROW_W'(hits.size() + 1);
        beat.last    = 1'b0;
        expected_keys.push_back(beat);
      end
      beat.key     = KEY_W'(q);
      beat.row_len = ROW_W'(hits.size() + 1);
      beat.last    = 1'b1;
      expected_keys.push_back(beat);
    end
  endtask

  always @(posedge clk) begin
    key_beat_t beat;
    if (rst) begin
      left_ptr = 0;
      span     = '0;
      expected_keys.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) span = cfg_ch.window;
      if (in_ch.valid && in_ch.ready)
        select_keys(in_ch.operation, in_ch.index, in_ch.raw_position,
                    in_ch.true_position, in_ch.expiry_value, in_ch.restart);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_keys.size() == 0) begin
          $error("unexpected result beat: key_index %0d row_length %0d last %0d",
                 out_ch.key_index, out_ch.row_length, out_ch.last);
          errors++;
        end else begin
          beat = expected_keys.pop_front();
          if (out_ch.key_index !== beat.key) begin
            $error("key_index: expected %0d, got %0d", beat.key, out_ch.key_index);
            errors++;
          end
          if (out_ch.row_length !== beat.row_len) begin
            $error("row_length: expected %0d, got %0d", beat.row_len, out_ch.row_length);
            errors++;
          end
          if (out_ch.last !== beat.last) begin
            $error("last: expected %0d, got %0d", beat.last, out_ch.last);
            errors++;
          end
        end
      end
    end
    pending    <= expected_keys.size();
    fail_count <= errors;
  end

endmodule

`default_nettype wire

>>> dv/sliding_window_key_selector_test.sv
// ----------------------------------------------------------------------------
// sliding_window_key_selector_test: testbench top
// Drives expiry writes, token loads and queries with random gaps and
// result-side stalls, changes the window between phases, and reports the
// verdict from the checker's failure count and backlog.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_key_selector_test import swks_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation code the block ignores.
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  localparam int QUIET_LIMIT   = 4000; // cycles with no beat on any channel
  localparam int HOLD_CYCLES   = 400;  // long result-side hold-off
  localparam int SETTLE_CYCLES = 12;   // block finishing up after last result
  localparam int IDLE_PCT      = 7;
  localparam int PHASE_ITEMS   = 60;
  localparam logic [WIN_W-1:0] WIN_MAX = '1;
  localparam logic [EXP_W-1:0] EXP_MAX = '1;
  localparam logic [POS_W-1:0] POS_MAX = '1;

  logic clk = 1'b0;
  logic rst;
  logic ready_q = 1'b0;
  logic calm = 1'b0;     // no random idling on either side
  int   hold_requests;   // bumped by stimulus to ask for a long hold-off
  int   hold_seen;
  int   hold_left;
  int   quiet;
  int   fail_count;
  int   pending;

  swks_in_if  in_ch ();
  swks_out_if out_ch ();
  swks_cfg_if cfg_ch ();

  always #5ns clk = ~clk;

  sliding_window_key_selector u_top (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch),
    .cfg (cfg_ch)
  );

  sliding_window_key_selector_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: random stalls, or a long hold-off counted here once the
  // stimulus asks for one.
  assign out_ch.ready = ready_q;

  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= HOLD_CYCLES;
      ready_q   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      ready_q   <= 1'b0;
    end else begin
      ready_q <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: a stretch with no beat anywhere means the block is stuck.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Offer one item and hold it until accepted. Valid stays high afterwards
  // so back-to-back items need no extra edge; gaps and drains lower it.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                           input logic [RAW_W-1:0] raw, input logic [POS_W-1:0] pos,
                           input logic [EXP_W-1:0] expv, input logic restart);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.operation     <= op;
    in_ch.index         <= idx;
    in_ch.raw_position  <= raw;
    in_ch.true_position <= pos;
    in_ch.expiry_value  <= expv;
    in_ch.restart       <= restart;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop offering and wait until every queued key beat has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Window register write, only with the block idle.
  task automatic set_window(input logic [WIN_W-1:0] span);
    drain();
    // loads and writes leave no result behind; let the last one retire
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid  <= 1'b1;
    cfg_ch.window <= span;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Expiry values mostly near the raw range so visibility flips often.
  function automatic logic [EXP_W-1:0] pick_expiry();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return EXP_W'($urandom_range(0, 280));
    if (roll < 85) return EXP_W'($urandom);
    return (roll < 92) ? '0 : EXP_MAX;
  endfunction

  initial begin
    logic [WIN_W-1:0] phase_span [4];
    logic [POS_W-1:0] pos_cursor;
    logic [RAW_W-1:0] raw;
    logic [POS_W-1:0] pos;
    bit               exp_ok [RAW_DEPTH_DEF];
    int               loaded;  // tokens 0..loaded-1 written, their expiries too
    int               last_q;
    int               made;
    int               roll;
    int               q;
    bit               held;
    bit               paused;

    rst                 <= 1'b1;
    in_ch.valid         <= 1'b0;
    in_ch.operation     <= OP_EXPIRY;
    in_ch.index         <= '0;
    in_ch.raw_position  <= '0;
    in_ch.true_position <= '0;
    in_ch.expiry_value  <= '0;
    in_ch.restart       <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.window       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part, window at its reset value of zero ----
    // ignored op
    send_item(OP_NONE, IDX_W'($urandom), RAW_W'($urandom), POS_W'($urandom),
              EXP_W'($urandom), 1'b1);
    send_item(OP_EXPIRY, 8'd255, RAW_W'($urandom), POS_W'($urandom), EXP_MAX, 1'b0);
    send_item(OP_EXPIRY, 8'd0, RAW_W'($urandom), POS_W'($urandom), '0, 1'b0);
    send_item(OP_EXPIRY, 8'd10, RAW_W'($urandom), POS_W'($urandom), 31'd100, 1'b0);
    send_item(OP_EXPIRY, 8'd200, RAW_W'($urandom), POS_W'($urandom), 31'd201, 1'b0);
    send_item(OP_LOAD, 8'd0, 8'd255, '0, EXP_W'($urandom), 1'b0);
    send_item(OP_LOAD, 8'd1, 8'd10, 31'd5, EXP_W'($urandom), 1'b0);
    // expiry zero: never seen
    send_item(OP_LOAD, 8'd2, 8'd0, 31'd10, EXP_W'($urandom), 1'b0);
    send_item(OP_LOAD, 8'd3, 8'd200, POS_MAX, EXP_W'($urandom), 1'b0);
    // out of range
    send_item(OP_LOAD, 8'd255, RAW_W'($urandom), POS_W'($urandom),
              EXP_W'($urandom), 1'b0);
    // nothing earlier
    send_item(OP_QUERY, 8'd0, RAW_W'($urandom), POS_W'($urandom),
              EXP_W'($urandom), 1'b1);
    // zero window: pointer runs all the way up to the query
    send_item(OP_QUERY, 8'd3, RAW_W'($urandom), POS_W'($urandom),
              EXP_W'($urandom), 1'b1);
    // pointer now past these queries: each emits only itself
    send_item(OP_QUERY, 8'd1, RAW_W'($urandom), POS_W'($urandom),
              EXP_W'($urandom), 1'b0);
    // out-of-range query with restart must not move the pointer
    send_item(OP_QUERY, 8'd200, RAW_W'($urandom), POS_W'($urandom),
              EXP_W'($urandom), 1'b1);
    send_item(OP_QUERY, 8'd2, RAW_W'($urandom), POS_W'($urandom),
              EXP_W'($urandom), 1'b0);
    // restart on a write does nothing
    send_item(OP_EXPIRY, 8'd20, RAW_W'($urandom), POS_W'($urandom), 31'd30, 1'b1);
    send_item(OP_QUERY, 8'd2, RAW_W'($urandom), POS_W'($urandom),
              EXP_W'($urandom), 1'b1);
    set_window(WIN_MAX);
    // threshold is zero: scan from token 0
    send_item(OP_QUERY, 8'd3, RAW_W'($urandom), POS_W'($urandom),
              EXP_W'($urandom), 1'b1);
    // move token 3 down so the pointer can get past it later
    send_item(OP_LOAD, 8'd3, 8'd20, 31'd15, EXP_W'($urandom), 1'b1);
    send_item(OP_QUERY, 8'd3, RAW_W'($urandom), POS_W'($urandom),
              EXP_W'($urandom), 1'b0);

    foreach (exp_ok[i]) exp_ok[i] = 1'b0;
    exp_ok[255] = 1'b1;
    exp_ok[0]   = 1'b1;
    exp_ok[10]  = 1'b1;
    exp_ok[200] = 1'b1;
    exp_ok[20]  = 1'b1;
    loaded     = 4;
    last_q     = 0;
    pos_cursor = 31'd20;
    held       = 1'b0;
    paused     = 1'b0;

    // ---- random part: one window per phase ----
    phase_span[0] = 31'd45;
    phase_span[1] = '0;
    phase_span[2] = WIN_MAX;
    phase_span[3] = WIN_W'($urandom);
    for (int ph = 0; ph < 4; ph++) begin
      set_window(phase_span[ph]);
      calm <= (ph == 2);  // one phase runs with no idling at all
      made = 0;
      while (made < PHASE_ITEMS) begin
        if (ph == 3 && !held && made >= 20) begin
          // deaf receiver while a long query is offered and more follow
          held = 1'b1;
          hold_requests <= hold_requests + 1;
          send_item(OP_QUERY, IDX_W'(loaded - 1), RAW_W'($urandom), POS_W'($urandom),
                    EXP_W'($urandom), 1'b1);
          made++;
        end
        if (ph == 3 && !paused && made >= 45) begin
          paused = 1'b1;
          drain();
        end
        roll = $urandom_range(99);
        if (roll < 8) begin
          // noise: ignored op, load or query past the token tables
          case ($urandom_range(2))
            0: send_item(OP_NONE, IDX_W'($urandom), RAW_W'($urandom), POS_W'($urandom),
                         EXP_W'($urandom), 1'($urandom_range(1)));
            1: send_item(OP_LOAD,
                         IDX_W'($urandom_range(TOKEN_DEPTH_DEF, 2**IDX_W - 1)),
                         RAW_W'($urandom), POS_W'($urandom), EXP_W'($urandom),
                         1'($urandom_range(1)));
            default: send_item(OP_QUERY,
                               IDX_W'($urandom_range(TOKEN_DEPTH_DEF, 2**IDX_W - 1)),
                               RAW_W'($urandom), POS_W'($urandom), EXP_W'($urandom),
                               1'($urandom_range(1)));
          endcase
        end else if (roll < 22) begin
          q = $urandom_range(RAW_DEPTH_DEF - 1);
          exp_ok[q] = 1'b1;
          send_item(OP_EXPIRY, IDX_W'(q), RAW_W'($urandom), POS_W'($urandom),
                    pick_expiry(), 1'($urandom_range(1)));
          made++;
        end else if (roll < 58 || loaded == 0) begin
          // grow the loaded prefix, then overwrite within it
          if (loaded < TOKEN_DEPTH_DEF) begin
            q = loaded;
            loaded++;
          end else begin
            q = $urandom_range(TOKEN_DEPTH_DEF - 1);
          end
          raw = RAW_W'($urandom_range(RAW_DEPTH_DEF - 1));
          if ($urandom_range(99) < 4) begin
            pos = POS_W'($urandom);
          end else begin
            pos_cursor = pos_cursor + POS_W'($urandom_range(0, 40));
            pos = pos_cursor;
          end
          send_item(OP_LOAD, IDX_W'(q), raw, pos, EXP_W'($urandom),
                    1'($urandom_range(1)));
          made++;
          // a key's expiry slot must exist before any query scans it
          if (!exp_ok[raw]) begin
            exp_ok[raw] = 1'b1;
            send_item(OP_EXPIRY, raw, RAW_W'($urandom), POS_W'($urandom), pick_expiry(),
                      1'($urandom_range(1)));
            made++;
          end
        end else begin
          // mostly creeping forward, like a decode stream; sometimes anywhere
          if ($urandom_range(99) < 60) q = last_q + $urandom_range(0, 3);
          else q = $urandom_range(loaded - 1);
          if (q >= loaded) q = loaded - 1;
          last_q = q;
          send_item(OP_QUERY, IDX_W'(q), RAW_W'($urandom), POS_W'($urandom),
                    EXP_W'($urandom), $urandom_range(99) < 15);
          made++;
        end
      end
    end

    drain();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
